[rtl/core/event_clip_preroll_buffer_core_macros.svh]
// assertion macros shared by the clip pre-roll buffer rtl
`ifndef EVENT_CLIP_PREROLL_BUFFER_CORE_MACROS_SVH
`define EVENT_CLIP_PREROLL_BUFFER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ECPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ECPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ecpb_pkg.sv]
// types and codes of the clip pre-roll buffer
package ecpb_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_BUFFERED   = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_ABANDONED  = 3'd4,
        ST_ARMED      = 3'd5,
        ST_EMPTY      = 3'd6,
        ST_SUPPRESSED = 3'd7
    } status_t;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_WALK_RD  = 7'b0000100,
        S_WALK_CHK = 7'b0001000,
        S_HEAD_RD  = 7'b0010000,
        S_CLIP     = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    // register indexes
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_PRE_WIN  = 3'd1;
    localparam logic [2:0] REG_POST_WIN = 3'd2;
    localparam logic [2:0] REG_COOLDOWN = 3'd3;
    localparam logic [2:0] REG_MAX_BYTES = 3'd4;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 264;

    // saturating counter step
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

[rtl/core/ecpb_ring_mem.sv]
// descriptor ring storage: one write port, one registered read port
module ecpb_ring_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 73
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/event_clip_preroll_buffer_core.sv]
// top level of the event clip pre-roll buffer
// Takes frame descriptors and detection events one word at a time and returns one
// result word each. An event, or a frame that is ignored, dropped, abandoned or
// appended during a capture, passes S_EXEC and then S_DONE; a frame that ends a
// capture passes S_EXEC, S_HEAD_RD, S_CLIP and S_DONE; a frame appended while no
// capture runs walks the ring from its oldest entry to find the trim point, one
// S_WALK_RD and one S_WALK_CHK per entry visited through the single read port of
// the ring memory. A new word is taken once the previous result has moved into
// the output register, where it may still wait on m_tready.
// No clearing pass runs after reset.
`include "event_clip_preroll_buffer_core_macros.svh"

module event_clip_preroll_buffer_core #(
    parameter int RING_DEPTH = 256,
    parameter int TIME_BITS  = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_len[23:0], frame_ts[71:24], is_keyframe[72], event_tag[104:73]
    input  logic [ecpb_pkg::IN_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic         s_tuser,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], held_frames[11:3], held_bytes[43:12], capturing[44],
    // cooldown_on[45], clip_frames[54:46], clip_bytes[86:55],
    // clip_first_timestamp[134:87], clip_tag[166:135], armed_count[198:167],
    // suppressed_count[230:199], failed_count[262:231]
    output logic [ecpb_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int BW = 24 + CW;
    localparam int MW = TIME_BITS + 25;

    // configuration registers
    logic        enable_reg;
    logic [31:0] pre_win_reg;
    logic [31:0] post_win_reg;
    logic [31:0] cooldown_reg;
    logic [31:0] max_bytes_reg;

    // block state
    ecpb_pkg::state_t st_reg;
    logic [AW-1:0]        head_reg;
    logic [CW-1:0]        count_reg;
    logic [BW-1:0]        bytes_reg;
    logic [TIME_BITS-1:0] latest_reg;
    logic [TIME_BITS-1:0] trig_time_reg;
    logic                 has_trig_reg;
    logic                 cap_reg;
    logic [TIME_BITS:0]   deadline_reg;
    logic [31:0]          cap_tag_reg;
    logic [31:0]          armed_reg;
    logic [31:0]          supp_reg;
    logic [31:0]          failed_reg;

    // latched input word
    logic                 in_kind_reg;
    logic [23:0]          in_len_reg;
    logic [TIME_BITS-1:0] in_ts_reg;
    logic                 in_key_reg;
    logic [31:0]          in_tag_reg;

    // trim walk
    logic [CW-1:0] walk_i_reg;
    logic [CW-1:0] drop_reg;
    logic [BW-1:0] drop_bytes_reg;
    logic [BW-1:0] sum_reg;

    // step result
    ecpb_pkg::status_t status_reg;
    logic [8:0]        clip_frames_reg;
    logic [31:0]       clip_bytes_reg;
    logic [47:0]       clip_ts_reg;
    logic [31:0]       clip_tag_reg;

    logic         m_valid_reg;
    logic [ecpb_pkg::OUT_DATA_W-1:0] m_data_reg;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] rd_data;

    // helpers
    logic          cfg_wr;
    logic [CW:0]   tail_sum;
    logic [CW:0]   walk_sum;
    logic [CW:0]   drop_sum;
    logic [BW-1:0] bytes_add;
    logic          cooling;
    logic [TIME_BITS:0]   cool_diff;
    logic [TIME_BITS+1:0] cutoff;
    logic [TIME_BITS-1:0] rd_ts;
    logic [23:0]          rd_len;
    logic                 rd_key;
    logic                 rd_after_cut;
    logic [31:0]          bytes_sat;
    logic                 chk_idle_cap;
    logic                 chk_accept;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (st_reg == ecpb_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            ecpb_pkg::REG_ENABLE:    prdata = {31'd0, enable_reg};
            ecpb_pkg::REG_PRE_WIN:   prdata = pre_win_reg;
            ecpb_pkg::REG_POST_WIN:  prdata = post_win_reg;
            ecpb_pkg::REG_COOLDOWN:  prdata = cooldown_reg;
            ecpb_pkg::REG_MAX_BYTES: prdata = max_bytes_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    // ring addressing with wrap
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign walk_sum = (CW+1)'(head_reg) + (CW+1)'(walk_i_reg);
    assign drop_sum = (CW+1)'(head_reg) + (CW+1)'(drop_reg);
    assign wr_addr  = (tail_sum >= (CW+1)'(RING_DEPTH)) ?
                      AW'(tail_sum - (CW+1)'(RING_DEPTH)) : AW'(tail_sum);
    assign rd_addr  = (st_reg == ecpb_pkg::S_WALK_RD) ?
                      ((walk_sum >= (CW+1)'(RING_DEPTH)) ?
                       AW'(walk_sum - (CW+1)'(RING_DEPTH)) : AW'(walk_sum)) : head_reg;

    assign wr_en = (st_reg == ecpb_pkg::S_EXEC) && !in_kind_reg && enable_reg &&
                   (in_len_reg != 24'd0) && !(count_reg == '0 && !in_key_reg) &&
                   (count_reg < CW'(RING_DEPTH));

    ecpb_ring_mem #(
        .DEPTH (RING_DEPTH),
        .WIDTH (MW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_key_reg, in_len_reg, in_ts_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_ts  = rd_data[TIME_BITS-1:0];
    assign rd_len = rd_data[TIME_BITS +: 24];
    assign rd_key = rd_data[MW-1];

    // signed time compares
    assign bytes_add = bytes_reg + BW'(in_len_reg);
    assign cool_diff = {1'b0, latest_reg} - {1'b0, trig_time_reg};
    assign cooling   = cap_reg ||
                       (has_trig_reg && ($signed(cool_diff) <
                        $signed({{(TIME_BITS-32){1'b0}}, 1'b0, cooldown_reg})));
    assign cutoff    = {2'b00, latest_reg} - {{(TIME_BITS-30){1'b0}}, pre_win_reg};
    assign rd_after_cut = $signed({2'b00, rd_ts}) > $signed(cutoff);
    assign bytes_sat = (bytes_reg > BW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(bytes_reg);

    // sequencer and state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ecpb_pkg::S_IDLE;
            enable_reg    <= 1'b0;
            pre_win_reg   <= 32'd5000000;
            post_win_reg  <= 32'd10000000;
            cooldown_reg  <= 32'd30000000;
            max_bytes_reg <= 32'd16777216;
            head_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            latest_reg    <= '0;
            trig_time_reg <= '0;
            has_trig_reg  <= 1'b0;
            cap_reg       <= 1'b0;
            deadline_reg  <= '0;
            cap_tag_reg   <= '0;
            armed_reg     <= '0;
            supp_reg      <= '0;
            failed_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && st_reg != ecpb_pkg::S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            // configuration writes
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    ecpb_pkg::REG_ENABLE: begin
                        enable_reg <= pwdata[0];
                        if (!pwdata[0]) begin
                            head_reg    <= '0;
                            count_reg   <= '0;
                            bytes_reg   <= '0;
                            cap_reg     <= 1'b0;
                            cap_tag_reg <= '0;
                        end
                    end
                    ecpb_pkg::REG_PRE_WIN:   pre_win_reg   <= pwdata;
                    ecpb_pkg::REG_POST_WIN:  post_win_reg  <= pwdata;
                    ecpb_pkg::REG_COOLDOWN:  cooldown_reg  <= pwdata;
                    ecpb_pkg::REG_MAX_BYTES: max_bytes_reg <= pwdata;
                    default: ;
                endcase
            end
            unique case (st_reg)
                ecpb_pkg::S_IDLE: begin
                    if (s_tvalid) begin
                        in_kind_reg <= s_tuser;
                        in_len_reg  <= s_tdata[23:0];
                        in_ts_reg   <= TIME_BITS'(s_tdata[71:24]);
                        in_key_reg  <= s_tdata[72];
                        in_tag_reg  <= s_tdata[104:73];
                        st_reg      <= ecpb_pkg::S_EXEC;
                    end
                end
                ecpb_pkg::S_EXEC: begin
                    clip_frames_reg <= '0;
                    clip_bytes_reg  <= '0;
                    clip_ts_reg     <= '0;
                    clip_tag_reg    <= '0;
                    if (!in_kind_reg) begin
                        if (!enable_reg || in_len_reg == 24'd0) begin
                            status_reg <= ecpb_pkg::ST_IGNORED;
                            st_reg     <= ecpb_pkg::S_DONE;
                        end else if (count_reg == '0 && !in_key_reg) begin
                            status_reg <= ecpb_pkg::ST_DROPPED;
                            st_reg     <= ecpb_pkg::S_DONE;
                        end else if (count_reg >= CW'(RING_DEPTH)) begin
                            head_reg   <= '0;
                            count_reg  <= '0;
                            bytes_reg  <= '0;
                            status_reg <= ecpb_pkg::ST_ABANDONED;
                            st_reg     <= ecpb_pkg::S_DONE;
                            if (cap_reg) begin
                                cap_reg     <= 1'b0;
                                cap_tag_reg <= '0;
                                failed_reg  <= ecpb_pkg::sat_inc(failed_reg);
                            end
                        end else if (!cap_reg) begin
                            count_reg      <= count_reg + CW'(1);
                            bytes_reg      <= bytes_add;
                            latest_reg     <= in_ts_reg;
                            status_reg     <= ecpb_pkg::ST_BUFFERED;
                            walk_i_reg     <= '0;
                            drop_reg       <= '0;
                            drop_bytes_reg <= '0;
                            sum_reg        <= '0;
                            st_reg         <= ecpb_pkg::S_WALK_RD;
                        end else if ({1'b0, in_ts_reg} >= deadline_reg) begin
                            count_reg  <= count_reg + CW'(1);
                            bytes_reg  <= bytes_add;
                            latest_reg <= in_ts_reg;
                            st_reg     <= ecpb_pkg::S_HEAD_RD;
                        end else if (bytes_add > BW'(max_bytes_reg)) begin
                            head_reg    <= '0;
                            count_reg   <= '0;
                            bytes_reg   <= '0;
                            latest_reg  <= in_ts_reg;
                            cap_reg     <= 1'b0;
                            cap_tag_reg <= '0;
                            failed_reg  <= ecpb_pkg::sat_inc(failed_reg);
                            status_reg  <= ecpb_pkg::ST_ABANDONED;
                            st_reg      <= ecpb_pkg::S_DONE;
                        end else begin
                            count_reg  <= count_reg + CW'(1);
                            bytes_reg  <= bytes_add;
                            latest_reg <= in_ts_reg;
                            status_reg <= ecpb_pkg::ST_BUFFERED;
                            st_reg     <= ecpb_pkg::S_DONE;
                        end
                    end else begin
                        st_reg <= ecpb_pkg::S_DONE;
                        if (!enable_reg) begin
                            status_reg <= ecpb_pkg::ST_IGNORED;
                        end else if (count_reg == '0) begin
                            status_reg <= ecpb_pkg::ST_EMPTY;
                        end else if (cooling) begin
                            supp_reg   <= ecpb_pkg::sat_inc(supp_reg);
                            status_reg <= ecpb_pkg::ST_SUPPRESSED;
                        end else begin
                            has_trig_reg  <= 1'b1;
                            trig_time_reg <= latest_reg;
                            cap_reg       <= 1'b1;
                            deadline_reg  <= {1'b0, latest_reg} +
                                             (TIME_BITS+1)'(post_win_reg);
                            cap_tag_reg   <= in_tag_reg;
                            armed_reg     <= ecpb_pkg::sat_inc(armed_reg);
                            status_reg    <= ecpb_pkg::ST_ARMED;
                        end
                    end
                end
                // issue one ring read, or finish the trim
                ecpb_pkg::S_WALK_RD: begin
                    if (walk_i_reg == count_reg) begin
                        head_reg  <= (drop_sum >= (CW+1)'(RING_DEPTH)) ?
                                     AW'(drop_sum - (CW+1)'(RING_DEPTH)) : AW'(drop_sum);
                        count_reg <= count_reg - drop_reg;
                        bytes_reg <= bytes_reg - drop_bytes_reg;
                        st_reg    <= ecpb_pkg::S_DONE;
                    end else begin
                        st_reg <= ecpb_pkg::S_WALK_CHK;
                    end
                end
                // examine one entry: stop past the cutoff, remember keyframes
                ecpb_pkg::S_WALK_CHK: begin
                    if (rd_after_cut) begin
                        head_reg  <= (drop_sum >= (CW+1)'(RING_DEPTH)) ?
                                     AW'(drop_sum - (CW+1)'(RING_DEPTH)) : AW'(drop_sum);
                        count_reg <= count_reg - drop_reg;
                        bytes_reg <= bytes_reg - drop_bytes_reg;
                        st_reg    <= ecpb_pkg::S_DONE;
                    end else begin
                        if (rd_key) begin
                            drop_reg       <= walk_i_reg;
                            drop_bytes_reg <= sum_reg;
                        end
                        sum_reg    <= sum_reg + BW'(rd_len);
                        walk_i_reg <= walk_i_reg + CW'(1);
                        st_reg     <= ecpb_pkg::S_WALK_RD;
                    end
                end
                ecpb_pkg::S_HEAD_RD: begin
                    st_reg <= ecpb_pkg::S_CLIP;
                end
                // dispatch the whole ring as a clip
                ecpb_pkg::S_CLIP: begin
                    clip_frames_reg <= 9'(count_reg);
                    clip_bytes_reg  <= bytes_sat;
                    clip_ts_reg     <= 48'(rd_ts);
                    clip_tag_reg    <= cap_tag_reg;
                    head_reg        <= '0;
                    count_reg       <= '0;
                    bytes_reg       <= '0;
                    cap_reg         <= 1'b0;
                    cap_tag_reg     <= '0;
                    status_reg      <= ecpb_pkg::ST_DISPATCHED;
                    st_reg          <= ecpb_pkg::S_DONE;
                end
                // hand the result to the output register
                ecpb_pkg::S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, failed_reg, supp_reg, armed_reg,
                                        clip_tag_reg, clip_ts_reg, clip_bytes_reg,
                                        clip_frames_reg, enable_reg && cooling, cap_reg,
                                        bytes_sat, 9'(count_reg), status_reg};
                        st_reg      <= ecpb_pkg::S_IDLE;
                    end
                end
                default: st_reg <= ecpb_pkg::S_IDLE;
            endcase
        end
    end

    // checks
    assign chk_idle_cap = (st_reg == ecpb_pkg::S_IDLE) && cap_reg;
    assign chk_accept   = s_tvalid && s_tready && !cfg_wr;

    `ECPB_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(RING_DEPTH), "count")
    `ECPB_ASSERT_IMPL(a_cap_nonempty, aclk, aresetn, chk_idle_cap, count_reg != '0, "empty")
    `ECPB_ASSERT_NEXT(a_accept_busy, aclk, aresetn, chk_accept, st_reg == ecpb_pkg::S_EXEC, "lost")

endmodule
